// ----- rtl/record_ring_drop_oldest_core_macros.svh -----
// assertion macros for the record ring core
// used by the top level, which supplies i_clk and i_rst_n in scope
`ifndef RECORD_RING_DROP_OLDEST_CORE_MACROS_SVH
`define RECORD_RING_DROP_OLDEST_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RRDO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RRDO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RRDO_ASSERT_IMP(lbl, ante, cons)
`define RRDO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rrdo_pkg.sv -----
// shared types and constants of the record ring core
// no dependencies
`default_nettype none
package rrdo_pkg;
    // ring geometry
    localparam int RING_BYTES = 65536;
    localparam int ADDR_W     = $clog2(RING_BYTES);
    localparam logic [ADDR_W-1:0] RING_MASK = ADDR_W'(RING_BYTES - 1);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 16;
    localparam int DROP_W    = 9;
    localparam int MAX_DROPS = 256;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_REWIND = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [BYTE_W-1:0]   record_length;
        logic [BYTE_W-1:0]   data_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic                byte_valid;
        logic                record_end;
        logic                log_end;
        logic [DROP_W-1:0]   dropped_records;
        logic [FILL_W-1:0]   fill_bytes;
        logic                misuse;
    } t_out_item;

    // ring memory access request from the sequencer
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- rtl/rrdo_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module rrdo_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rrdo_ctrl.sv -----
// sequencer of the record ring: pointers, drop and read walks, result register
// depends on rrdo_pkg
`default_nettype none
module rrdo_ctrl
    import rrdo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire t_in_item          i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_out_item         o_out_data,
    output      t_mem_req          o_mem_req,
    input  wire logic [BYTE_W-1:0] i_rdata
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP_CHK,
        S_DROP_WAIT,
        S_RD_CHK,
        S_RD_PFX,
        S_RD_DATA
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_oldest, n_oldest;
    logic [ADDR_W-1:0]  r_rp, n_rp;
    logic [BYTE_W-1:0]  r_left_app, n_left_app;
    logic [BYTE_W-1:0]  r_left_rd, n_left_rd;
    logic               r_open, n_open;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [DROP_W-1:0]  r_dropped, n_dropped;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [ADDR_W-1:0]  used;
    logic [ADDR_W-1:0]  free_bytes;
    logic [DROP_W-1:0]  total;
    logic               need_drop;
    logic               out_free;
    logic               in_fire;
    logic               load;
    t_out_item          res;
    t_mem_req           mem_req;

    // space check for the pending start
    assign used       = r_head - r_oldest;
    assign free_bytes = RING_MASK - used;
    assign total      = {1'b0, r_len} + DROP_W'(1);
    assign need_drop  = (free_bytes < ADDR_W'(total)) && (used != '0)
                        && (r_dropped != DROP_W'(MAX_DROPS));

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // next-state and datapath
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_oldest    = r_oldest;
        n_rp        = r_rp;
        n_left_app  = r_left_app;
        n_left_rd   = r_left_rd;
        n_open      = r_open;
        n_len       = r_len;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        res         = '0;
        load        = 1'b0;
        mem_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.opcode)
                        OP_START: begin
                            if (r_open) begin
                                res.misuse = 1'b1;
                                load       = 1'b1;
                            end else begin
                                n_len     = i_in_data.record_length;
                                n_dropped = '0;
                                n_state   = S_DROP_CHK;
                            end
                        end
                        OP_APPEND: begin
                            if (!r_open) begin
                                res.misuse = 1'b1;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_head;
                                mem_req.wdata = i_in_data.data_byte;
                                n_head        = r_head + ADDR_W'(1);
                                n_left_app    = r_left_app - BYTE_W'(1);
                                if (n_left_app == '0) begin
                                    n_open = 1'b0;
                                end
                            end
                            load = 1'b1;
                        end
                        OP_REWIND: begin
                            n_rp      = r_oldest;
                            n_left_rd = '0;
                            load      = 1'b1;
                        end
                        OP_READ: begin
                            if (r_open) begin
                                res.misuse = 1'b1;
                                load       = 1'b1;
                            end else begin
                                n_state = S_RD_CHK;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            // drop the oldest record or write the prefix
            S_DROP_CHK: begin
                if (need_drop) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_oldest;
                    n_state       = S_DROP_WAIT;
                end else if (out_free) begin
                    if (r_dropped != '0) begin
                        n_rp      = r_oldest;
                        n_left_rd = '0;
                    end
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = r_head;
                    mem_req.wdata       = r_len;
                    n_head              = r_head + ADDR_W'(1);
                    n_left_app          = r_len;
                    n_open              = (r_len != '0);
                    res.dropped_records = r_dropped;
                    load                = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_DROP_WAIT: begin
                n_oldest  = r_oldest + ADDR_W'(i_rdata) + ADDR_W'(1);
                n_dropped = r_dropped + DROP_W'(1);
                n_state   = S_DROP_CHK;
            end
            // reader walk: skip prefixes until a data byte or the head
            S_RD_CHK: begin
                if ((r_left_rd == '0) && (r_rp != r_head)) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_rp;
                    n_state       = S_RD_PFX;
                end else if ((r_left_rd == '0) || (r_rp == r_head)) begin
                    if (out_free) begin
                        n_left_rd   = '0;
                        res.log_end = 1'b1;
                        load        = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_rp;
                    n_state       = S_RD_DATA;
                end
            end
            S_RD_PFX: begin
                n_left_rd = i_rdata;
                n_rp      = r_rp + ADDR_W'(1);
                n_state   = S_RD_CHK;
            end
            S_RD_DATA: begin
                if (out_free) begin
                    res.data_out   = i_rdata;
                    res.byte_valid = 1'b1;
                    res.record_end = (r_left_rd == BYTE_W'(1));
                    n_rp           = r_rp + ADDR_W'(1);
                    n_left_rd      = r_left_rd - BYTE_W'(1);
                    load           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result beat with the fill level after this step
        if (load) begin
            n_out            = res;
            n_out.fill_bytes = FILL_W'(n_head - n_oldest);
            n_out_valid      = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_len      <= n_len;
        r_dropped  <= n_dropped;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_oldest    <= '0;
            r_rp        <= '0;
            r_left_app  <= '0;
            r_left_rd   <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_oldest    <= n_oldest;
            r_rp        <= n_rp;
            r_left_app  <= n_left_app;
            r_left_rd   <= n_left_rd;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_mem_req   = mem_req;
endmodule
`default_nettype wire

// ----- rtl/record_ring_drop_oldest_core.sv -----
// append, rewind and rejected beats are loaded into the output register as they are accepted
// start: each dropped record is one ring read of the oldest prefix (S_DROP_CHK, S_DROP_WAIT)
// read: one S_RD_CHK/S_RD_PFX pass per prefix skipped, then S_RD_DATA for a data byte
// one append or rewind per cycle if the output is free; start and read block input until done
// reset clears pointers, byte counts and the result valid flag; ring contents are not cleared
`default_nettype none
`include "record_ring_drop_oldest_core_macros.svh"
module record_ring_drop_oldest_core
    import rrdo_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_ready,
    input  wire t_in_item  i_in_data,
    output      logic      o_out_valid,
    input  wire logic      i_out_ready,
    output      t_out_item o_out_data
);
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] rdata;

    // sequencer
    rrdo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_req   (mem_req),
        .i_rdata     (rdata)
    );

    // ring storage
    rrdo_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    // checks
    `RRDO_ASSERT_IMP(a_no_rw_same_cycle, mem_req.we, !mem_req.re)
    `RRDO_ASSERT_IMP(a_ready_needs_slot, o_in_ready, !o_out_valid || i_out_ready)
    `RRDO_ASSERT_IMP(a_byte_or_end, o_out_valid, !(o_out_data.byte_valid && o_out_data.log_end))
    `RRDO_ASSERT_IMP(a_misuse_clean, o_out_valid && o_out_data.misuse,
        !o_out_data.byte_valid && !o_out_data.log_end && (o_out_data.dropped_records == '0))
endmodule
`default_nettype wire

// ----- verif/record_ring_checker.sv -----
// checker for the record ring core: watches both channels, predicts every result beat
// from its own copy of the ring and compares it with what the core returns
// depends on rrdo_pkg for the beat types and ring geometry
module record_ring_checker
    import rrdo_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_beats,
    output int             o_bytes_read,
    output int             o_drops,
    output int             o_drop_peak,
    output int             o_misuse
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor copy of the ring and its pointers
    logic [BYTE_W-1:0] ring_mem [RING_BYTES];
    logic [ADDR_W-1:0] head_ptr    = '0;
    logic [ADDR_W-1:0] oldest_ptr  = '0;
    logic [ADDR_W-1:0] rd_ptr      = '0;
    logic [BYTE_W-1:0] append_left = '0;
    logic [BYTE_W-1:0] read_left   = '0;
    logic              rec_open    = 1'b0;

    // results owed by the core, oldest first
    t_out_item ring_results_due[$];

    int err_count    = 0;
    int beat_count   = 0;
    int byte_count   = 0;
    int drop_count   = 0;
    int drop_peak    = 0;
    int misuse_count = 0;

    // advance the ring copy by one input beat and return the result it causes
    function automatic t_out_item apply_ring_op(input t_in_item beat);
        t_out_item res;
        int        drops;
        int        need;
        int        guard;
        res   = '0;
        drops = 0;
        guard = 0;
        need  = int'(beat.record_length) + 1;
        case (beat.opcode)
            OP_START: begin
                if (rec_open) begin
                    res.misuse = 1'b1;
                end else begin
                    // drop whole records from the oldest end until the new one fits
                    while (drops < MAX_DROPS && head_ptr != oldest_ptr &&
                           int'(RING_MASK) - int'(ADDR_W'(head_ptr - oldest_ptr)) < need) begin
                        oldest_ptr = oldest_ptr + ADDR_W'(ring_mem[oldest_ptr]) + 1'b1;
                        drops++;
                    end
                    if (drops != 0) begin
                        rd_ptr    = oldest_ptr;
                        read_left = '0;
                    end
                    ring_mem[head_ptr] = beat.record_length;
                    head_ptr           = head_ptr + 1'b1;
                    append_left        = beat.record_length;
                    rec_open           = (beat.record_length != '0);
                end
            end
            OP_APPEND: begin
                if (!rec_open) begin
                    res.misuse = 1'b1;
                end else begin
                    ring_mem[head_ptr] = beat.data_byte;
                    head_ptr           = head_ptr + 1'b1;
                    append_left        = append_left - 1'b1;
                    if (append_left == '0) begin
                        rec_open = 1'b0;
                    end
                end
            end
            OP_REWIND: begin
                rd_ptr    = oldest_ptr;
                read_left = '0;
            end
            default: begin
                if (rec_open) begin
                    res.misuse = 1'b1;
                end else begin
                    // step over length prefixes until a data byte or the head
                    while (read_left == '0 && rd_ptr != head_ptr && guard < RING_BYTES) begin
                        read_left = ring_mem[rd_ptr];
                        rd_ptr    = rd_ptr + 1'b1;
                        guard++;
                    end
                    if (read_left == '0 || rd_ptr == head_ptr) begin
                        read_left   = '0;
                        res.log_end = 1'b1;
                    end else begin
                        res.data_out   = ring_mem[rd_ptr];
                        rd_ptr         = rd_ptr + 1'b1;
                        read_left      = read_left - 1'b1;
                        res.byte_valid = 1'b1;
                        res.record_end = (read_left == '0);
                    end
                end
            end
        endcase
        res.dropped_records = DROP_W'(drops);
        res.fill_bytes      = head_ptr - oldest_ptr;
        return res;
    endfunction

    function automatic string show_result(input t_out_item r);
        return $sformatf("data=%02h byte_valid=%b record_end=%b log_end=%b dropped=%0d fill=%0d misuse=%b",
                         r.data_out, r.byte_valid, r.record_end, r.log_end,
                         r.dropped_records, r.fill_bytes, r.misuse);
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_out_item want;
        string     bad;
        if (!i_rst_n) begin
            head_ptr    = '0;
            oldest_ptr  = '0;
            rd_ptr      = '0;
            append_left = '0;
            read_left   = '0;
            rec_open    = 1'b0;
            ring_results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                want = apply_ring_op(i_in_data);
                ring_results_due.push_back(want);
                beat_count++;
                if (want.byte_valid) byte_count++;
                if (want.misuse) misuse_count++;
                drop_count += int'(want.dropped_records);
                if (int'(want.dropped_records) > drop_peak) drop_peak = int'(want.dropped_records);
            end
            if (i_out_valid && i_out_ready) begin
                if (ring_results_due.size() == 0) begin
                    err_count++;
                    $display("%0t: result beat with nothing expected: got %s",
                             $time, show_result(i_out_data));
                end else begin
                    want = ring_results_due.pop_front();
                    bad  = "";
                    if (i_out_data.data_out        !== want.data_out)        bad = {bad, " data_out"};
                    if (i_out_data.byte_valid      !== want.byte_valid)      bad = {bad, " byte_valid"};
                    if (i_out_data.record_end      !== want.record_end)      bad = {bad, " record_end"};
                    if (i_out_data.log_end         !== want.log_end)         bad = {bad, " log_end"};
                    if (i_out_data.dropped_records !== want.dropped_records) bad = {bad, " dropped"};
                    if (i_out_data.fill_bytes      !== want.fill_bytes)      bad = {bad, " fill"};
                    if (i_out_data.misuse          !== want.misuse)          bad = {bad, " misuse"};
                    if (bad != "") begin
                        err_count++;
                        $display("%0t: mismatch in%s: expected %s, got %s",
                                 $time, bad, show_result(want), show_result(i_out_data));
                    end
                end
            end
        end
        o_errors     <= err_count;
        o_pending    <= ring_results_due.size();
        o_beats      <= beat_count;
        o_bytes_read <= byte_count;
        o_drops      <= drop_count;
        o_drop_peak  <= drop_peak;
        o_misuse     <= misuse_count;
    end
endmodule

// ----- verif/tb.sv -----
// top of the record ring testbench: clock, reset, stimulus and verdict
// depends on rrdo_pkg, record_ring_drop_oldest_core and record_ring_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrdo_pkg::*;

    localparam int RANDOM_BEATS  = 1100;
    localparam int ZERO_RECORDS  = 100;
    localparam int FULL_RECORDS  = 1;
    localparam int TAIL_RECORDS  = 2;
    localparam int DRAIN_CYCLES  = 64;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    int err_total;
    int pending;
    int beats;
    int bytes_read;
    int drops;
    int drop_peak;
    int misuse;

    // idling percentages for the current phase
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    // data bytes still owed to the open record, mirrored for sequence building
    int open_left  = 0;
    int sent_count = 0;

    record_ring_drop_oldest_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    record_ring_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_errors     (err_total),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_bytes_read (bytes_read),
        .o_drops      (drops),
        .o_drop_peak  (drop_peak),
        .o_misuse     (misuse)
    );

    always #2 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= (rcv_stall_pct == 0) || ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
            default: begin snd_idle_pct = 38; rcv_stall_pct = 38; end
        endcase
    endtask

    // drive one input beat and wait for it to be taken
    task automatic send_beat(input t_opcode op, input logic [7:0] len, input logic [7:0] dat);
        t_in_item beat;
        beat.opcode        = op;
        beat.record_length = len;
        beat.data_byte     = dat;
        while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_START && open_left == 0) open_left = int'(len);
        else if (op == OP_APPEND && open_left != 0) open_left--;
        sent_count++;
    endtask

    // close whatever record a stray start left open
    task automatic finish_open();
        while (open_left != 0) send_beat(OP_APPEND, rnd8(), rnd8());
    endtask

    // a stray beat in the middle of an open record: rewind or a rejected read/start
    task automatic send_in_record_noise();
        case ($urandom_range(0, 2))
            0: send_beat(OP_REWIND, rnd8(), rnd8());
            1: send_beat(OP_READ, rnd8(), rnd8());
            default: send_beat(OP_START, rnd8(), rnd8());
        endcase
    endtask

    task automatic write_record(input int len, input int noise_pct);
        send_beat(OP_START, 8'(len), rnd8());
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_in_record_noise();
            send_beat(OP_APPEND, rnd8(), rnd8());
        end
    endtask

    task automatic read_burst(input int n, input bit from_oldest);
        if (from_oldest) send_beat(OP_REWIND, rnd8(), rnd8());
        repeat (n) send_beat(OP_READ, rnd8(), rnd8());
    endtask

    // edges of the fields and every protocol corner once
    task automatic run_directed();
        set_idle_mode(0);
        send_beat(OP_READ,   8'h00, 8'h00);   // read of an empty log
        send_beat(OP_APPEND, 8'h00, 8'hFF);   // append with nothing open
        send_beat(OP_START,  8'h00, 8'h00);   // zero-length record
        send_beat(OP_START,  8'd3,  8'hFF);
        send_beat(OP_START,  8'hFF, 8'h00);   // start while a record is open
        send_beat(OP_READ,   8'hFF, 8'hFF);   // read while a record is open
        send_beat(OP_REWIND, 8'h00, 8'h00);   // rewind while a record is open
        send_beat(OP_APPEND, 8'hFF, 8'h00);
        send_beat(OP_APPEND, 8'h00, 8'hFF);
        send_beat(OP_APPEND, 8'h5A, 8'hA5);
        send_beat(OP_APPEND, 8'h00, 8'h3C);   // append after the record closed
        send_beat(OP_START,  8'd1,  8'h00);
        send_beat(OP_APPEND, 8'h00, 8'h81);
        send_beat(OP_REWIND, 8'hFF, 8'hFF);
        // skip the empty record, read both records, then hit the head twice
        repeat (6) send_beat(OP_READ, 8'h00, 8'h00);
    endtask

    // mostly well-formed traffic with misuse mixed in, idling phase per 150 beats
    task automatic run_random(input int goal);
        int base;
        int pick;
        int len;
        base = sent_count;
        while (sent_count - base < goal) begin
            set_idle_mode(((sent_count - base) / 150) % 4);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                finish_open();
                len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(13, 255);
                write_record(len, 8);
            end else if (pick < 75) begin
                read_burst($urandom_range(1, 24), $urandom_range(0, 1));
            end else if (pick < 85) begin
                send_beat(OP_REWIND, rnd8(), rnd8());
            end else begin
                send_beat(t_opcode'($urandom_range(0, 3)), rnd8(), rnd8());
            end
        end
    endtask

    // a run of empty records followed by full-length and random-length records,
    // with reads that have to step over the empty prefixes
    task automatic run_fill();
        int rec;
        rec = 0;
        finish_open();
        repeat (ZERO_RECORDS) send_beat(OP_START, 8'h00, rnd8());
        while (rec < FULL_RECORDS + TAIL_RECORDS) begin
            set_idle_mode((sent_count / 4000) % 4);
            write_record((rec < FULL_RECORDS) ? 255 : $urandom_range(0, 255), 1);
            if ($urandom_range(0, 15) == 0) begin
                read_burst($urandom_range(1, 8), $urandom_range(0, 3) != 0);
            end
            rec++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(RANDOM_BEATS);
        run_fill();
        i_in_valid <= 1'b0;
        // let the checker register the last beat before watching its count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d beats: %0d bytes read back, %0d rejected beats", beats,
                 bytes_read, misuse);
        $display("%0d oldest records dropped in all, up to %0d by one start", drops,
                 drop_peak);
        if (err_total == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hard stop if the core hangs
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
